// ===== sv/rkbc_pkg.sv =====
package rkbc_pkg;

  // Register map, one 64-bit register every 8 bytes
  typedef enum logic [2:0] {
    REG_CRYPT_MODE = 3'd0,
    REG_KEY_LENGTH = 3'd1,
    REG_KEY_WORD_0 = 3'd2,
    REG_KEY_WORD_1 = 3'd3,
    REG_KEY_WORD_2 = 3'd4,
    REG_KEY_WORD_3 = 3'd5
  } reg_idx_e;

  localparam int unsigned KeyWords = 4;

  localparam logic [7:0] KeyMaskEven = 8'h55;
  localparam logic [7:0] KeyMaskOdd  = 8'hAA;
  localparam logic [7:0] DeltaReset  = 8'd32;
  localparam logic [5:0] LenReset    = 6'd32;

  localparam logic CryptEncrypt = 1'b0;
  localparam logic CryptDecrypt = 1'b1;

  // Scramble mask for a key byte, chosen by the parity of its position
  function automatic logic [7:0] key_mask(input logic odd);
    return odd ? KeyMaskOdd : KeyMaskEven;
  endfunction

endpackage

// ===== sv/rolling_key_byte_cipher.sv =====
// Rolling-key byte cipher.
//
// Input channel: data_byte_i with restart_i, handshaked by in_valid_i and
// in_ready_o. A beat with restart_i high reloads the working key from the
// key registers (scrambled with 0x55 / 0xAA), clears the key position and
// sets the running delta to the key length before that byte is handled.
// Output channel: out_byte_o, handshaked by out_valid_o and out_ready_i.
// Each input beat yields exactly one output beat, in order.
//
// An input beat is registered into the compute stage together with the key
// RAM read; the combine, delta update and key write-back then retire it into
// the output register. Throughput is one byte per clock unless the receiver
// stalls, set by the single read port and single write port of the key RAM;
// back-to-back bytes on the same key entry use a write-to-read bypass.
//
// Reset loads the key state of an all-zero key of length 32 through valid
// bits, so no clearing pass is needed and the block is ready at once.
// When the receiver stalls, the output register holds its beat; one more byte
// may sit in the compute stage, after which in_ready_o drops. The user must
// write the APB port (64-bit registers at 8*index) only while idle; not enforced.
module rolling_key_byte_cipher #(
  parameter int unsigned MAX_KEY_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        restart_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o
);
  import rkbc_pkg::*;

  localparam int unsigned PosW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic        mode_q;
  logic [5:0]  len_q;
  logic [63:0] key_word_q [KeyWords];
  logic        cfg_fire;
  reg_idx_e    cfg_idx;

  assign cfg_fire = psel && penable && pwrite;
  assign cfg_idx  = reg_idx_e'(paddr[5:3]);
  assign pready   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= CryptEncrypt;
      len_q  <= LenReset;
      for (int i = 0; i < KeyWords; i++) begin
        key_word_q[i] <= '0;
      end
    end else if (cfg_fire) begin
      case (cfg_idx)
        REG_CRYPT_MODE: mode_q        <= pwdata[0];
        REG_KEY_LENGTH: len_q         <= pwdata[5:0];
        REG_KEY_WORD_0: key_word_q[0] <= pwdata;
        REG_KEY_WORD_1: key_word_q[1] <= pwdata;
        REG_KEY_WORD_2: key_word_q[2] <= pwdata;
        REG_KEY_WORD_3: key_word_q[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CRYPT_MODE: prdata = {63'd0, mode_q};
      REG_KEY_LENGTH: prdata = {58'd0, len_q};
      REG_KEY_WORD_0: prdata = key_word_q[0];
      REG_KEY_WORD_1: prdata = key_word_q[1];
      REG_KEY_WORD_2: prdata = key_word_q[2];
      REG_KEY_WORD_3: prdata = key_word_q[3];
      default:        prdata = '0;
    endcase
  end

  // Effective key length: zero counts as one, saturate at the key store size
  logic [5:0] eff_len;
  always_comb begin
    if (len_q == 6'd0) begin
      eff_len = 6'd1;
    end else if (len_q > 6'(MAX_KEY_BYTES)) begin
      eff_len = 6'(MAX_KEY_BYTES);
    end else begin
      eff_len = len_q;
    end
  end

  // ---------------------------------------------------------------------
  // Handshake and stage control
  // ---------------------------------------------------------------------
  logic s1_valid_q;
  logic out_valid_q;
  logic s1_fire;   // compute stage retires into the output register
  logic in_fire;

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------
  // Key position, advanced as each beat is taken
  // ---------------------------------------------------------------------
  logic [PosW-1:0] pos_q;
  logic [PosW-1:0] cur_pos;
  logic [5:0]      pos_inc;

  assign cur_pos = restart_i ? '0 : pos_q;
  assign pos_inc = 6'(cur_pos) + 6'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (in_fire) begin
      pos_q <= (pos_inc >= eff_len) ? '0 : pos_inc[PosW-1:0];
    end
  end

  // Snapshot of the raw key bytes taken at restart; unmodified entries
  // read from here so later register writes do not disturb the stream.
  logic [7:0] snap_q [MAX_KEY_BYTES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_KEY_BYTES; i++) begin
        snap_q[i] <= '0;
      end
    end else if (in_fire && restart_i) begin
      for (int i = 0; i < MAX_KEY_BYTES; i++) begin
        snap_q[i] <= key_word_q[i / 8][(i % 8) * 8 +: 8];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Working key RAM: holds entries modified since the last restart
  // ---------------------------------------------------------------------
  logic [7:0]         ram_rdata;
  logic [7:0]         key_new;
  logic [MAX_KEY_BYTES-1:0] mod_q;  // entry holds a modified value in RAM
  logic [MAX_KEY_BYTES-1:0] mod_d;

  logic [PosW-1:0] s1_pos_q;
  logic [7:0]      s1_data_q;
  logic            s1_restart_q;
  logic            fwd_hit_q;
  logic [7:0]      fwd_data_q;

  rkbc_ram #(
    .Width (8),
    .Depth (MAX_KEY_BYTES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_pos_q),
    .wdata_i (key_new),
    .re_i    (in_fire),
    .raddr_i (cur_pos),
    .rdata_o (ram_rdata)
  );

  // Compute stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Bypass: the retiring beat writes the same entry this beat is reading
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pos_q     <= cur_pos;
      s1_data_q    <= data_byte_i;
      s1_restart_q <= restart_i;
      fwd_hit_q    <= s1_fire && (s1_pos_q == cur_pos);
      fwd_data_q   <= key_new;
    end
  end

  // Pick the current key byte: restart takes the fresh scrambled key,
  // then the bypass, then the RAM for modified entries, else the snapshot.
  logic [7:0] key_cur;
  logic [7:0] delta_q;
  logic [7:0] delta_use;
  logic [7:0] res;

  always_comb begin
    if (s1_restart_q || !mod_q[s1_pos_q]) begin
      key_cur = snap_q[s1_pos_q] ^ key_mask(s1_pos_q[0]);
    end else if (fwd_hit_q) begin
      key_cur = fwd_data_q;
    end else begin
      key_cur = ram_rdata;
    end
  end

  assign key_new   = key_cur + 8'(s1_pos_q);
  assign delta_use = s1_restart_q ? 8'(eff_len) : delta_q;
  assign res       = s1_data_q ^ delta_use ^ key_cur;

  // Restart drops every modified mark; mark the entry this beat writes back
  always_comb begin
    mod_d           = s1_restart_q ? '0 : mod_q;
    mod_d[s1_pos_q] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_q <= DeltaReset;
      mod_q   <= '0;
    end else if (s1_fire) begin
      delta_q <= delta_use + ((mode_q == CryptDecrypt) ? res : s1_data_q);
      mod_q   <= mod_d;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic [7:0] out_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_byte_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_restart_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && restart_i |=> s1_pos_q == '0)
    else $error("restart beat did not start at key position zero");

  a_restart_clears_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_restart_q |=> $countones(mod_q) == 1)
    else $error("restart did not drop modified key entries");

  a_retire_marks_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> mod_q[$past(s1_pos_q)])
    else $error("retired key entry not marked modified");

  a_stage_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && !in_fire |=> !s1_valid_q)
    else $error("compute stage kept a retired beat");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_ready_i |-> !s1_fire)
    else $error("compute stage overwrote a held output beat");

endmodule

// ===== sv/rkbc_ram.sv =====
module rkbc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rkbc_pkg::*;

  // Generous ceiling, sized for the slowest receive pattern.
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomBytes = 1400;

  typedef enum int unsigned {
    RX_FREE,    // always ready
    RX_COIN,    // ready on a coin flip
    RX_SPARSE,  // ready only when rx_tick is a multiple of eight
    RX_MOSTLY   // ready seven times in eight, at random
  } rx_pattern_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        restart_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_byte_o;

  rolling_key_byte_cipher dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Cipher predictor: mirror of the register file and of the rolling key state.
  // ---------------------------------------------------------------------------
  logic        mode_reg;
  logic [5:0]  len_reg;
  logic [63:0] key_reg [KeyWords];
  logic [7:0]  key_ram [32];
  logic [4:0]  key_pos;
  logic [7:0]  delta;

  logic [7:0]  expected_out [$];   // predicted output bytes, oldest first
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;

  // Sender burst state
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  bit          valid_held = 1'b0;

  // Length in use: zero counts as one, anything past 32 saturates.
  function automatic int unsigned active_len();
    if (len_reg == 6'd0) return 1;
    if (len_reg > 6'd32) return 32;
    return int'(len_reg);
  endfunction

  // Scramble the configured key into the working key and rewind the stream.
  function automatic void reload_key();
    for (int i = 0; i < 32; i++) begin
      key_ram[i] = key_reg[i / 8][(i % 8) * 8 +: 8] ^ ((i % 2 != 0) ? KeyMaskOdd : KeyMaskEven);
    end
    key_pos = 5'd0;
    delta   = 8'(active_len());
  endfunction

  // Process one byte: combine with delta and key, fold the plaintext into the
  // delta, bump the used key byte by its position and advance the position.
  function automatic logic [7:0] cipher_step(input logic [7:0] d, input logic rs);
    logic [7:0]  k;
    logic [7:0]  res;
    int unsigned p;
    int unsigned nxt;
    if (rs) reload_key();
    p   = key_pos;
    k   = key_ram[p];
    res = d ^ delta ^ k;
    delta = delta + ((mode_reg == CryptDecrypt) ? res : d);
    key_ram[p] = k + 8'(p);
    nxt = p + 1;
    if (nxt >= active_len()) nxt = 0;
    key_pos = 5'(nxt);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("[%0t] mismatch, %s: got %02h, want %02h", $realtime, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: stall pattern and checker.
  // ---------------------------------------------------------------------------
  rx_pattern_e rx_pattern = RX_FREE;
  int unsigned rx_left    = 0;
  int unsigned rx_tick    = 0;

  // Switch to a random stall pattern whenever the rx_left countdown runs out.
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_pattern = rx_pattern_e'($urandom_range(0, 3));
      rx_left    = $urandom_range(16, 200);
    end else begin
      rx_left--;
    end
    rx_tick++;
    case (rx_pattern)
      RX_FREE:   out_ready_i <= 1'b1;
      RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready_i <= (rx_tick % 8 == 0);
      default:   out_ready_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Sample at the falling edge, where everything driven at the rising edge
  // has settled; a beat seen here is taken at the next rising edge.
  logic [7:0] want_byte;
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_out.size() == 0) begin
        report_mismatch("beat with no byte pending", out_byte_o, 8'h00);
      end else begin
        want_byte = expected_out.pop_front();
        if (out_byte_o !== want_byte) report_mismatch("out_byte", out_byte_o, want_byte);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL rolling_key_byte_cipher");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side.
  // ---------------------------------------------------------------------------

  // Send one byte; entered and left just after a rising edge. Bursts of random
  // length, and valid drops only when a burst ends with a real gap.
  task automatic send_byte(input logic [7:0] d, input logic rs);
    bit         took;
    logic [7:0] pred;
    if (gap_left != 0) begin
      repeat (gap_left) @(posedge clk_i);
      gap_left = 0;
    end
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= d;
    restart_i   <= rs;
    valid_held  = 1'b1;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    pred = cipher_step(d, rs);
    expected_out = {expected_out, pred};
    burst_left--;
    if (burst_left == 0) begin
      gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
      if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        valid_held = 1'b0;
      end
    end
  endtask

  // Drop valid, wait for every predicted byte to come out, then let the
  // pipeline settle.
  task automatic drain_pipeline();
    if (valid_held) begin
      in_valid_i <= 1'b0;
      valid_held = 1'b0;
    end
    while (expected_out.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then the access cycle; pready is always high.
  task automatic write_reg(input reg_idx_e idx, input logic [63:0] value);
    drain_pipeline();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CRYPT_MODE: mode_reg   = value[0];
      REG_KEY_LENGTH: len_reg    = value[5:0];
      REG_KEY_WORD_0: key_reg[0] = value;
      REG_KEY_WORD_1: key_reg[1] = value;
      REG_KEY_WORD_2: key_reg[2] = value;
      REG_KEY_WORD_3: key_reg[3] = value;
      default: ;
    endcase
  endtask

  function automatic logic [63:0] random_key_word();
    case ($urandom_range(0, 5))
      0:       return 64'h0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Length choice with the extremes and out-of-range values well represented.
  function automatic logic [5:0] random_key_len();
    case ($urandom_range(0, 9))
      0:       return 6'd1;
      1:       return 6'd32;
      2:       return 6'd0;
      3:       return 6'($urandom_range(33, 63));
      default: return 6'($urandom_range(1, 32));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Run straight off reset: the zero key of length 32, no restart.
  task automatic test_reset_state();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
  endtask

  // Extreme bytes, restarts on two successive bytes, extreme key words.
  task automatic test_byte_extremes();
    write_reg(REG_KEY_WORD_0, '1);
    write_reg(REG_KEY_WORD_1, 64'h0);
    write_reg(REG_KEY_WORD_2, 64'h0123_4567_89AB_CDEF);
    write_reg(REG_KEY_WORD_3, '1);
    write_reg(REG_KEY_LENGTH, 64'd32);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
  endtask

  // Encrypt a short message, then decrypt the ciphertext under the same key.
  task automatic test_round_trip();
    logic [7:0] plain [3] = '{8'h48, 8'hFE, 8'h00};
    logic [7:0] coded [3];
    write_reg(REG_CRYPT_MODE, {63'd0, CryptEncrypt});
    for (int i = 0; i < 3; i++) begin
      send_byte(plain[i], i == 0);
      coded[i] = expected_out[$];
    end
    write_reg(REG_CRYPT_MODE, {63'd0, CryptDecrypt});
    for (int i = 0; i < 3; i++) send_byte(coded[i], i == 0);
  endtask

  // Length zero acts as one (key byte 0 reused, bumped by zero); past 32 saturates.
  task automatic test_length_limits();
    write_reg(REG_KEY_LENGTH, 64'd0);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h3C, 1'b0);
    write_reg(REG_KEY_LENGTH, 64'd63);
    send_byte(8'hC3, 1'b1);
  endtask

  // Shrink the key under a running stream: the position past the new length
  // is used once more and then wraps. Flip the mode mid-stream as well.
  task automatic test_length_shrink();
    write_reg(REG_CRYPT_MODE, {63'd0, CryptEncrypt});
    write_reg(REG_KEY_LENGTH, 64'd32);
    for (int i = 0; i < 6; i++) send_byte(8'(8'h10 + i), i == 0);
    write_reg(REG_KEY_LENGTH, 64'd3);
    write_reg(REG_CRYPT_MODE, {63'd0, CryptDecrypt});
    send_byte(8'h7F, 1'b0);
    send_byte(8'hE1, 1'b0);
    send_byte(8'h22, 1'b0);
  endtask

  // Random settings, then messages that start with a restart; some messages
  // carry on from the last one, some restart part way, and the length or mode
  // changes now and then under a live stream.
  task automatic test_random_messages();
    int unsigned sent;
    int unsigned phase_end;
    int unsigned msg_len;
    logic        rs;
    sent = 0;
    while (sent < RandomBytes) begin
      write_reg(REG_CRYPT_MODE, {63'd0, 1'($urandom_range(0, 1))});
      write_reg(REG_KEY_LENGTH, {58'd0, random_key_len()});
      write_reg(REG_KEY_WORD_0, random_key_word());
      write_reg(REG_KEY_WORD_1, random_key_word());
      write_reg(REG_KEY_WORD_2, random_key_word());
      write_reg(REG_KEY_WORD_3, random_key_word());
      phase_end = sent + $urandom_range(60, 160);
      while (sent < phase_end && sent < RandomBytes) begin
        msg_len = $urandom_range(1, 70);
        for (int j = 0; j < msg_len; j++) begin
          if (j == 0) rs = ($urandom_range(0, 9) != 0);
          else rs = ($urandom_range(0, 39) == 0);
          send_byte(8'($urandom_range(0, 255)), rs);
          sent++;
        end
        case ($urandom_range(0, 11))
          0: write_reg(REG_KEY_LENGTH, 64'($urandom_range(0, 63)));
          1: write_reg(REG_CRYPT_MODE, {63'd0, !mode_reg});
          default: ;
        endcase
      end
    end
  endtask

  initial begin
    // Drive every input to a known value before the first edge.
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    restart_i   = 1'b0;
    out_ready_i = 1'b0;

    mode_reg = CryptEncrypt;
    len_reg  = LenReset;
    for (int i = 0; i < KeyWords; i++) key_reg[i] = 64'h0;
    reload_key();
    delta = DeltaReset;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_byte_extremes();
    test_round_trip();
    test_length_limits();
    test_length_shrink();
    test_random_messages();
    drain_pipeline();
    repeat (8) @(posedge clk_i);

    if (mismatches == 0 && expected_out.size() == 0) begin
      $display("PASS rolling_key_byte_cipher");
    end else begin
      $display("FAIL rolling_key_byte_cipher");
    end
    $finish;
  end

endmodule
